### hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

### hdl/msft_pkg.sv
// shared constants for the manchester sensor frame transmitter
// frame geometry, register indexes, transmit phase codes and request type codes; no dependencies
package msft_pkg;

   localparam int MESSAGE_BYTES = 5;
   localparam int SYNC_PAIRS    = 6;
   localparam int FRAME_BITS    = 8 * MESSAGE_BYTES;
   localparam int SYNC_BITS     = 2 * SYNC_PAIRS;
   localparam int PRE_BITS      = 4;
   localparam int HEAD_BITS     = 32;
   localparam int BITS_W        = $clog2(FRAME_BITS + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_HALF_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAUSE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PREAMBLE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SENSOR_TYPE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_ID   = 3'd5;

   localparam int PHASE_W = 3;

   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEAD  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SYNC  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PRE   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_TERM  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_PAUSE = 3'd6;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

endpackage

### hdl/manchester_sensor_frame_transmitter.sv
// Takes one item per clock: a tick advances the Manchester line by one timebase
// tick, a start loads a sensor frame and begins the repeated transmission (a start
// while busy is rejected). Each item produces exactly one result in the cycle
// after it is accepted, held in an output register; req_tready drops only while
// that register is full and rsp_tready is low, so with a free downstream the
// block sustains one item per cycle. All state updates for an item fit between
// the state registers and the output register. Half-period length, pause and
// preamble are read live; type, id and repeat count are captured at start.
// top level; depends on msft_pkg and assert_macros.svh
`include "assert_macros.svh"

module manchester_sensor_frame_transmitter (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: reading[15:0], battery_level[17:16], manual_trigger[18], zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,
   // req_tuser: req_type
   input  logic [0:0]                          req_tuser,
   // rsp_tdata: line_level, busy_res, done_res, rejected, zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,
   input  logic                                csr_we,
   input  logic [msft_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msft_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [15:0] half_period_ff;
   logic [7:0]  pause_halves_ff;
   logic [7:0]  repeat_count_ff;
   logic [3:0]  preamble_ff;
   logic [6:0]  sensor_type_ff;
   logic [5:0]  device_id_ff;

   logic [msft_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic [msft_pkg::BITS_W-1:0]     bits_left_ff, bits_left_in;
   logic                            second_half_ff, second_half_in;
   logic [15:0]                     tick_ff, tick_in;
   logic [7:0]                      pause_ff, pause_in;
   logic [7:0]                      repeats_ff, repeats_in;
   logic [msft_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic                            line_ff, line_in;

   logic       rsp_valid_ff;
   logic [3:0] rsp_data_ff;

   logic        accept;
   logic        done;
   logic        rej;
   logic [15:0] tick_inc;
   logic [15:0] half_eff;
   logic        half_end;
   logic [7:0]  repeats_dec;
   logic [msft_pkg::HEAD_BITS-1:0] frame_head;
   logic        cur_bit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff  <= 16'd1;
         pause_halves_ff <= 8'd4;
         repeat_count_ff <= 8'd3;
         preamble_ff     <= 4'd12;
         sensor_type_ff  <= 7'd0;
         device_id_ff    <= 6'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            msft_pkg::REG_HALF_PERIOD: half_period_ff  <= csr_wdata;
            msft_pkg::REG_PAUSE:       pause_halves_ff <= csr_wdata[7:0];
            msft_pkg::REG_REPEAT:      repeat_count_ff <= csr_wdata[7:0];
            msft_pkg::REG_PREAMBLE:    preamble_ff     <= csr_wdata[3:0];
            msft_pkg::REG_SENSOR_TYPE: sensor_type_ff  <= csr_wdata[6:0];
            msft_pkg::REG_DEVICE_ID:   device_id_ff    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign tick_inc    = tick_ff + 16'd1;
   assign half_eff    = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
   assign half_end    = (tick_inc >= half_eff) || (tick_inc == 16'd0);
   assign repeats_dec = (repeats_ff != 8'd0) ? repeats_ff - 8'd1 : repeats_ff;
   assign frame_head  = {req_tdata[18], sensor_type_ff, req_tdata[17:16], device_id_ff,
                         req_tdata[7:0], req_tdata[15:8]};

   // next state for one item
   always_comb begin
      frame_in       = frame_ff;
      bits_left_in   = bits_left_ff;
      second_half_in = second_half_ff;
      tick_in        = tick_ff;
      pause_in       = pause_ff;
      repeats_in     = repeats_ff;
      phase_in       = phase_ff;
      line_in        = line_ff;
      done           = 1'b0;
      rej            = 1'b0;
      cur_bit        = 1'b0;
      if (accept) begin
         if (req_tuser[0] == msft_pkg::REQ_START) begin
            if (phase_ff != msft_pkg::PH_IDLE) begin
               rej = 1'b1;
            end else begin
               frame_in = msft_pkg::FRAME_BITS'(frame_head)
                          << (msft_pkg::FRAME_BITS - msft_pkg::HEAD_BITS);
               repeats_in     = repeat_count_ff;
               tick_in        = 16'd0;
               second_half_in = 1'b0;
               bits_left_in   = '0;
               pause_in       = 8'd0;
               line_in        = 1'b0;
               if (repeat_count_ff == 8'd0) begin
                  phase_in = msft_pkg::PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in = msft_pkg::PH_LEAD;
               end
            end
         end else if (phase_ff != msft_pkg::PH_IDLE) begin
            if (!half_end) begin
               tick_in = tick_inc;
            end else begin
               tick_in = 16'd0;
               unique case (phase_ff) inside
                  msft_pkg::PH_LEAD: begin
                     phase_in       = msft_pkg::PH_SYNC;
                     bits_left_in   = msft_pkg::BITS_W'(msft_pkg::SYNC_BITS);
                     second_half_in = 1'b0;
                  end
                  msft_pkg::PH_SYNC, msft_pkg::PH_PRE, msft_pkg::PH_DATA: begin
                     if (!second_half_ff) begin
                        second_half_in = 1'b1;
                     end else begin
                        second_half_in = 1'b0;
                        if (bits_left_ff != '0) begin
                           bits_left_in = bits_left_ff - 1'b1;
                        end
                        if (bits_left_ff <= msft_pkg::BITS_W'(1)) begin
                           if (phase_ff == msft_pkg::PH_SYNC) begin
                              phase_in     = msft_pkg::PH_PRE;
                              bits_left_in = msft_pkg::BITS_W'(msft_pkg::PRE_BITS);
                           end else if (phase_ff == msft_pkg::PH_PRE) begin
                              phase_in     = msft_pkg::PH_DATA;
                              bits_left_in = msft_pkg::BITS_W'(msft_pkg::FRAME_BITS);
                           end else begin
                              phase_in = msft_pkg::PH_TERM;
                           end
                        end
                     end
                  end
                  msft_pkg::PH_TERM: begin
                     pause_in = pause_halves_ff;
                     if (pause_halves_ff == 8'd0) begin
                        repeats_in = repeats_dec;
                        if (repeats_dec != 8'd0) begin
                           phase_in = msft_pkg::PH_LEAD;
                        end else begin
                           phase_in = msft_pkg::PH_IDLE;
                           done     = 1'b1;
                        end
                     end else begin
                        phase_in = msft_pkg::PH_PAUSE;
                     end
                  end
                  msft_pkg::PH_PAUSE: begin
                     if (pause_ff != 8'd0) begin
                        pause_in = pause_ff - 8'd1;
                     end
                     if (pause_ff <= 8'd1) begin
                        repeats_in = repeats_dec;
                        if (repeats_dec != 8'd0) begin
                           phase_in = msft_pkg::PH_LEAD;
                        end else begin
                           phase_in = msft_pkg::PH_IDLE;
                           done     = 1'b1;
                        end
                     end
                  end
                  default: phase_in = msft_pkg::PH_IDLE;
               endcase
               // line level for the new half period
               case (phase_in)
                  msft_pkg::PH_SYNC: cur_bit = !bits_left_in[0];
                  msft_pkg::PH_PRE:  cur_bit = preamble_ff[2'(bits_left_in - 1'b1)];
                  msft_pkg::PH_DATA:
                     cur_bit = frame_ff[msft_pkg::BITS_W'(bits_left_in - 1'b1)];
                  default:           cur_bit = 1'b0;
               endcase
               case (phase_in) inside
                  msft_pkg::PH_SYNC, msft_pkg::PH_PRE, msft_pkg::PH_DATA:
                     line_in = second_half_in ? cur_bit : !cur_bit;
                  msft_pkg::PH_TERM: line_in = 1'b1;
                  default:           line_in = 1'b0;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff   <= '0;
         second_half_ff <= 1'b0;
         tick_ff        <= 16'd0;
         pause_ff       <= 8'd0;
         repeats_ff     <= 8'd0;
         phase_ff       <= msft_pkg::PH_IDLE;
         line_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bits_left_ff   <= bits_left_in;
         second_half_ff <= second_half_in;
         tick_ff        <= tick_in;
         pause_ff       <= pause_in;
         repeats_ff     <= repeats_in;
         phase_ff       <= phase_in;
         line_ff        <= line_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (accept) begin
         rsp_data_ff <= {rej, done, phase_in != msft_pkg::PH_IDLE, line_in};
      end
   end

   `ASSERT_NEVER(a_idle_line_low, clock, reset,
      (phase_ff == msft_pkg::PH_IDLE) && line_ff, "line high while idle")
   `ASSERT_CLK(a_term_line_high, clock, reset,
      (phase_ff == msft_pkg::PH_TERM) |-> line_ff, "terminating half not high")
   `ASSERT_CLK(a_second_half_in_bits, clock, reset,
      second_half_ff |-> (phase_ff == msft_pkg::PH_SYNC || phase_ff == msft_pkg::PH_PRE ||
                          phase_ff == msft_pkg::PH_DATA), "second half outside bit phase")
   `ASSERT_CLK(a_no_accept_when_full, clock, reset,
      (rsp_valid_ff && !rsp_tready) |-> !req_tready, "item accepted over a held result")
   `ASSERT_CLK(a_bits_left_range, clock, reset,
      (phase_ff == msft_pkg::PH_DATA) |->
         (bits_left_ff != '0 && bits_left_ff <= msft_pkg::BITS_W'(msft_pkg::FRAME_BITS)),
      "data bit count out of range")

endmodule
